>>> sv/assert_macros.svh
// shared assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CV3_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cv3 check failed");

// consequent checked in the cycle after the antecedent
`define CV3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cv3 check failed");

`endif

>>> sv/cv3_pkg.sv
package cv3_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned CFG_W      = 48;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned PROD_W     = 25;
  localparam int unsigned PSUM_W     = 27;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned POS_LIMIT  = 4096;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd3;
  localparam logic [DIM_W-1:0] HEIGHT_CAP = 13'd4096;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TOP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_MIDDLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT      = 3'd4;

  localparam logic [CFG_W-1:0] COEF_TOP_RESET    = 48'h0000_0000_0000;
  localparam logic [CFG_W-1:0] COEF_MIDDLE_RESET = 48'h0000_0100_0000;
  localparam logic [CFG_W-1:0] COEF_BOTTOM_RESET = 48'h0000_0000_0000;
  localparam logic [DIM_W-1:0] WIDTH_RESET       = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET      = 13'd480;

  typedef logic [PIX_W-1:0] pix_t;
  // one window column, index 0 is the top row
  typedef pix_t [2:0] pcol_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0] ccol_t;
  typedef logic signed [PSUM_W-1:0] psum_t;

  typedef struct packed {
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             end_of_frame;
  } tag_t;

  typedef struct packed {
    pix_t filtered;
    tag_t tag;
  } res_t;

endpackage

>>> sv/cv3_line_store.sv
module cv3_line_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output cv3_pkg::pix_t     rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  cv3_pkg::pix_t     wr_data_i
);

  cv3_pkg::pix_t mem_q [Depth];
  cv3_pkg::pix_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/cv3_cell.sv
module cv3_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  cv3_pkg::pcol_t  pix_i,
  input  cv3_pkg::ccol_t  coef_i,
  input  logic            calc_i,
  output cv3_pkg::pcol_t  pix_o,
  output cv3_pkg::psum_t  psum_o
);

  cv3_pkg::pcol_t pix_q;
  cv3_pkg::psum_t psum_q;
  cv3_pkg::psum_t psum_d;
  logic signed [cv3_pkg::PROD_W-1:0] prod [3];

  // pixel is unsigned, so it gets a zero sign bit before the signed multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = $signed({1'b0, pix_q[k]}) * $signed(coef_i[k]);
    end
    psum_d = cv3_pkg::PSUM_W'(prod[0]) + cv3_pkg::PSUM_W'(prod[1])
           + cv3_pkg::PSUM_W'(prod[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_i) begin
      psum_q <= psum_d;
    end
  end

  assign pix_o  = pix_q;
  assign psum_o = psum_q;

endmodule

>>> sv/cv3_out_fifo.sv
module cv3_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cv3_pkg::res_t                 push_data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output cv3_pkg::res_t                 data_o,
  output logic [cv3_pkg::FIFO_AW:0]     count_o
);

  cv3_pkg::res_t                  mem_q [cv3_pkg::FIFO_DEPTH];
  logic [cv3_pkg::FIFO_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [cv3_pkg::FIFO_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [cv3_pkg::FIFO_AW:0]      count_q, count_d;
  logic                           pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/conv3x3_clamped_image_filter.sv
// 3x3 convolution over a raster-order stream of 8-bit grayscale pixels.
// s_axis carries one pixel per item. m_axis carries one result item for every
// input pixel at row >= 2 and column >= 2: the filtered value of the window
// centered one row up and one column left, its center row and column, and
// tlast on the last interior pixel of the frame. Border pixels give no item.
// The cfg channel writes the coefficient rows, width and height; it is always
// ready. The user must write it only while the block holds no pending work;
// the block does not enforce this. A taken pixel passes the line stores, column
// cells, sum and clamp into an 8-entry output queue. Throughput: one pixel per
// clock while s_axis_tready is high, set by the line stores, which do one read
// and one write per pixel, and by the three column cells that shift once per
// pixel. s_axis_tready drops when the queue plus the items in flight reach
// eight, so a stalled receiver stops input and no result is lost.
// Reset: position goes to the frame start, coefficients to the identity
// kernel, size to 640 x 480. The line stores are not cleared; every entry is
// written in the first rows of a frame before it is used.
module conv3x3_clamped_image_filter #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel [7:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,
  // filtered [7:0], center_row [19:8], center_col [31:20]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cv3_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [cv3_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned WidthCap = (MAX_WIDTH < cv3_pkg::POS_LIMIT) ? MAX_WIDTH
                                                                      : cv3_pkg::POS_LIMIT;
  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam logic [cv3_pkg::DIM_W-1:0] WidthCapV = cv3_pkg::DIM_W'(WidthCap);
  localparam int unsigned DW = cv3_pkg::DIM_W;
  localparam int unsigned PW = cv3_pkg::POS_W;

  // configuration
  logic [cv3_pkg::CFG_W-1:0] coef_q [3];
  logic [DW-1:0]             width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= cv3_pkg::COEF_TOP_RESET;
      coef_q[1] <= cv3_pkg::COEF_MIDDLE_RESET;
      coef_q[2] <= cv3_pkg::COEF_BOTTOM_RESET;
      width_q   <= cv3_pkg::WIDTH_RESET;
      height_q  <= cv3_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cv3_pkg::REG_COEF_TOP:    coef_q[0] <= cfg_data_i;
        cv3_pkg::REG_COEF_MIDDLE: coef_q[1] <= cfg_data_i;
        cv3_pkg::REG_COEF_BOTTOM: coef_q[2] <= cfg_data_i;
        cv3_pkg::REG_WIDTH:       width_q   <= cfg_data_i[DW-1:0];
        cv3_pkg::REG_HEIGHT:      height_q  <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [DW-1:0] eff_w, eff_h;

  always_comb begin
    if (width_q < cv3_pkg::DIM_MIN) begin
      eff_w = cv3_pkg::DIM_MIN;
    end else if (width_q > WidthCapV) begin
      eff_w = WidthCapV;
    end else begin
      eff_w = width_q;
    end
    if (height_q < cv3_pkg::DIM_MIN) begin
      eff_h = cv3_pkg::DIM_MIN;
    end else if (height_q > cv3_pkg::HEIGHT_CAP) begin
      eff_h = cv3_pkg::HEIGHT_CAP;
    end else begin
      eff_h = height_q;
    end
  end

  // raster position
  logic [PW-1:0] col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [PW-1:0] col_cur, row_cur;
  logic [DW-1:0] row_pre, col_nxt, row_nxt;
  logic          wrap_pre, emit_cur, eof_cur;
  logic          in_acc;

  always_comb begin
    // a size change may leave the stored position at or past the new limit
    wrap_pre = ({1'b0, col_cnt_q} >= eff_w);
    col_cur  = wrap_pre ? '0 : col_cnt_q;
    row_pre  = wrap_pre ? {1'b0, row_cnt_q} + 1'b1 : {1'b0, row_cnt_q};
    row_cur  = (row_pre >= eff_h) ? '0 : row_pre[PW-1:0];
    col_nxt  = {1'b0, col_cur} + 1'b1;
    row_nxt  = {1'b0, row_cur} + 1'b1;
    if (col_nxt >= eff_w) begin
      col_cnt_d = '0;
      row_cnt_d = (row_nxt >= eff_h) ? '0 : row_nxt[PW-1:0];
    end else begin
      col_cnt_d = col_nxt[PW-1:0];
      row_cnt_d = row_cur;
    end
    emit_cur = (row_cur >= 12'd2) && (col_cur >= 12'd2);
    eof_cur  = ({1'b0, row_cur} == eff_h - 1'b1) && ({1'b0, col_cur} == eff_w - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // stage 1: line stores read at the item's column
  logic            v1_q, v2_q, v3_q, v4_q;
  logic            emit1_q;
  cv3_pkg::pix_t   px1_q;
  logic [PW-1:0]   col1_q;
  cv3_pkg::tag_t   tag1_q, tag2_q, tag3_q, tag4_q;
  cv3_pkg::pix_t   up_rd, lo_rd;
  logic signed [cv3_pkg::SUM_W-1:0] sum4_q;

  cv3_line_store #(
    .Depth (MAX_WIDTH)
  ) u_store_upper (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (AddrW'(col_cur)),
    .rd_data_o (up_rd),
    .wr_en_i   (v1_q),
    .wr_addr_i (AddrW'(col1_q)),
    .wr_data_i (lo_rd)
  );

  cv3_line_store #(
    .Depth (MAX_WIDTH)
  ) u_store_lower (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (AddrW'(col_cur)),
    .rd_data_o (lo_rd),
    .wr_en_i   (v1_q),
    .wr_addr_i (AddrW'(col1_q)),
    .wr_data_i (px1_q)
  );

  // window: cell 2 takes the newest column, cells hand columns leftward
  cv3_pkg::pcol_t cell_in  [3];
  cv3_pkg::pcol_t cell_pix [3];
  cv3_pkg::ccol_t cell_coef [3];
  cv3_pkg::psum_t cell_psum [3];

  always_comb begin
    cell_in[2][0] = up_rd;
    cell_in[2][1] = lo_rd;
    cell_in[2][2] = px1_q;
    cell_in[1]    = cell_pix[2];
    cell_in[0]    = cell_pix[1];
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        cell_coef[k][r] = coef_q[r][cv3_pkg::COEF_W*k +: cv3_pkg::COEF_W];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    cv3_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (v1_q),
      .pix_i   (cell_in[k]),
      .coef_i  (cell_coef[k]),
      .calc_i  (v2_q),
      .pix_o   (cell_pix[k]),
      .psum_o  (cell_psum[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q && emit1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q                 <= s_axis_tdata;
      col1_q                <= col_cur;
      emit1_q               <= emit_cur;
      tag1_q.center_row     <= row_cur - 1'b1;
      tag1_q.center_col     <= col_cur - 1'b1;
      tag1_q.end_of_frame   <= eof_cur;
    end
    tag2_q <= tag1_q;
    tag3_q <= tag2_q;
    tag4_q <= tag3_q;
    if (v3_q) begin
      sum4_q <= cv3_pkg::SUM_W'(cell_psum[0]) + cv3_pkg::SUM_W'(cell_psum[1])
              + cv3_pkg::SUM_W'(cell_psum[2]);
    end
  end

  // clamp: negative to 0, 256.0 and above to 255, else drop the fraction
  cv3_pkg::res_t push_res;

  always_comb begin
    push_res.tag = tag4_q;
    if (sum4_q[cv3_pkg::SUM_W-1]) begin
      push_res.filtered = cv3_pkg::PIX_MIN;
    end else if (sum4_q[cv3_pkg::SUM_W-2:16] != '0) begin
      push_res.filtered = cv3_pkg::PIX_MAX;
    end else begin
      push_res.filtered = sum4_q[15:8];
    end
  end

  logic [cv3_pkg::FIFO_AW:0]   fifo_count;
  logic [cv3_pkg::FIFO_AW+1:0] occupancy;
  cv3_pkg::res_t               out_res;

  cv3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (v4_q),
    .push_data_i (push_res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res),
    .count_o     (fifo_count)
  );

  // every item in flight may still need a queue entry
  assign occupancy = {1'b0, fifo_count} + (cv3_pkg::FIFO_AW+2)'(v1_q)
                   + (cv3_pkg::FIFO_AW+2)'(v2_q) + (cv3_pkg::FIFO_AW+2)'(v3_q)
                   + (cv3_pkg::FIFO_AW+2)'(v4_q);
  assign s_axis_tready = (occupancy < (cv3_pkg::FIFO_AW+2)'(cv3_pkg::FIFO_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata = {out_res.tag.center_col, out_res.tag.center_row, out_res.filtered};
  assign m_axis_tlast = out_res.tag.end_of_frame;

endmodule

>>> sv/cv3_checker.sv
`include "assert_macros.svh"

module cv3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      seen_in_q <= 1'b1;
    end
  end

  `CV3_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CV3_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `CV3_ASSERT_SAME(a_out_seen_in, m_axis_tvalid, $past(seen_in_q, 3))
  `CV3_ASSERT_SAME(a_pos_interior, m_axis_tvalid, (m_axis_tdata[19:8] != 12'd0) && (m_axis_tdata[31:20] != 12'd0))

endmodule

bind conv3x3_clamped_image_filter cv3_checker u_cv3_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cv3_pkg::*;

  localparam coef_t COEF_MAX      = 16'sh7FFF;
  localparam coef_t COEF_MIN      = 16'sh8000;
  localparam coef_t COEF_ONE_HALF = 16'sh0180;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_W-1:0]      data;
  } reg_write_t;

  // tracks line stores, window and position, and holds the filtered pixels still owed
  class conv_window_tracker;
    logic [CFG_W-1:0] coef_rows [3];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pix_t upper_line [POS_LIMIT];
    pix_t lower_line [POS_LIMIT];
    bit upper_written [POS_LIMIT];
    bit lower_written [POS_LIMIT];
    pix_t win [3][3];
    int unsigned col_cnt;
    int unsigned row_cnt;
    res_t expected_pixels [$];
    int unsigned failures;

    function new();
      coef_rows[0] = COEF_TOP_RESET;
      coef_rows[1] = COEF_MIDDLE_RESET;
      coef_rows[2] = COEF_BOTTOM_RESET;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
        upper_written[i] = 1'b0;
        lower_written[i] = 1'b0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col_cnt = 0;
      row_cnt = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_COEF_TOP:    coef_rows[0] = data;
        REG_COEF_MIDDLE: coef_rows[1] = data;
        REG_COEF_BOTTOM: coef_rows[2] = data;
        REG_WIDTH:       width_reg = data[DIM_W-1:0];
        REG_HEIGHT:      height_reg = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned width_of(logic [DIM_W-1:0] v);
      int unsigned w;
      w = v;
      if (w < DIM_MIN) w = DIM_MIN;
      if (w > POS_LIMIT) w = POS_LIMIT;
      return w;
    endfunction

    function int unsigned height_of(logic [DIM_W-1:0] v);
      int unsigned h;
      h = v;
      if (h < DIM_MIN) h = DIM_MIN;
      if (h > HEIGHT_CAP) h = HEIGHT_CAP;
      return h;
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    // widest row whose columns all hold written data in both line stores
    function int unsigned safe_width();
      int unsigned n;
      n = 0;
      while (n < POS_LIMIT && upper_written[n] && lower_written[n]) n++;
      return n;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function pix_t convolve_window();
      longint sum;
      coef_t k;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          k = coef_rows[r][COEF_W*c +: COEF_W];
          sum += longint'(win[r][c]) * longint'(k);
        end
      end
      if (sum < 0) return PIX_MIN;
      if (sum >= 256 * 256) return PIX_MAX;
      return pix_t'(sum >>> 8);
    endfunction

    function void note_pixel(pix_t px);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      res_t res;
      w = width_of(width_reg);
      h = height_of(height_reg);
      // a size change may leave the position past the new limits
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      col = col_cnt;
      row = row_cnt;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper_line[col];
      win[1][2] = lower_line[col];
      win[2][2] = px;
      upper_line[col] = lower_line[col];
      upper_written[col] = lower_written[col];
      lower_line[col] = px;
      lower_written[col] = 1'b1;
      if (row >= 2 && col >= 2) begin
        res.filtered = convolve_window();
        res.tag.center_row = POS_W'(row - 1);
        res.tag.center_col = POS_W'(col - 1);
        res.tag.end_of_frame = (row == h - 1 && col == w - 1);
        expected_pixels.push_back(res);
      end
      col_cnt = col + 1;
      row_cnt = row;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_result(logic [31:0] data, logic last);
      res_t want;
      if (expected_pixels.size() == 0) begin
        $error("result item with nothing pending: tdata %h tlast %b", data, last);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (data[7:0] !== want.filtered) begin
        $error("filtered: expected %0d, got %0d", want.filtered, data[7:0]);
        failures++;
      end
      if (data[19:8] !== want.tag.center_row) begin
        $error("center_row: expected %0d, got %0d", want.tag.center_row, data[19:8]);
        failures++;
      end
      if (data[31:20] !== want.tag.center_col) begin
        $error("center_col: expected %0d, got %0d", want.tag.center_col, data[31:20]);
        failures++;
      end
      if (last !== want.tag.end_of_frame) begin
        $error("end_of_frame: expected %0d, got %0d", want.tag.end_of_frame, last);
        failures++;
      end
    endfunction

    function void check_drained();
      if (expected_pixels.size() != 0) begin
        $error("%0d filtered pixels never came out", expected_pixels.size());
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  conv_window_tracker tracker = new();
  reg_write_t reg_writes [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_left = 0;

  conv3x3_clamped_image_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: check accepted items, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tlast);
    end
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic pix_t rand_pixel();
    case ($urandom_range(15))
      0: return PIX_MIN;
      1: return PIX_MAX;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pack_coefs(coef_t left, coef_t mid, coef_t right);
    return {right, mid, left};
  endfunction

  // kind 0: small signed taps, 1: any 16-bit value, else: small positive blur taps
  function automatic logic [CFG_W-1:0] random_coef_row(int unsigned kind);
    coef_t k [3];
    for (int c = 0; c < 3; c++) begin
      case (kind)
        0: k[c] = coef_t'(int'($urandom_range(768)) - 384);
        1: k[c] = coef_t'($urandom);
        default: k[c] = coef_t'($urandom_range(64));
      endcase
    end
    return pack_coefs(k[0], k[1], k[2]);
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 83; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
      default:       begin tx_idle_pct = 37; rx_stall_pct = 37; end
    endcase
  endtask

  task automatic queue_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
    reg_write_t wr;
    wr.idx = idx;
    wr.data = data;
    reg_writes.push_back(wr);
  endtask

  task automatic apply_writes();
    while (reg_writes.size() != 0) begin
      cfg_index_i <= reg_writes[0].idx;
      cfg_data_i <= reg_writes[0].data;
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker.write_reg(reg_writes[0].idx, reg_writes[0].data);
      void'(reg_writes.pop_front());
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pixel(pix_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_pixel(px);
  endtask

  task automatic stream(int unsigned n, bit to_frame_end);
    repeat (n) push_pixel(rand_pixel());
    if (to_frame_end) begin
      while (!tracker.at_frame_start()) push_pixel(rand_pixel());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // border pixels may still be in flight after the last result
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_frame(pix_t fill_px, pix_t mid_px, bit rand_fill);
    for (int i = 0; i < 9; i++) begin
      push_pixel((i == 4) ? mid_px : (rand_fill ? rand_pixel() : fill_px));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic random_setup();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CFG_W-1:0] junk;
    int unsigned kind;
    kind = $urandom_range(2);
    queue_write(REG_COEF_TOP, random_coef_row(kind));
    queue_write(REG_COEF_MIDDLE, random_coef_row(kind));
    queue_write(REG_COEF_BOTTOM, random_coef_row(kind));
    case ($urandom_range(9))
      0: w = DIM_W'($urandom_range(2));
      1: w = DIM_W'($urandom_range(40, 13));
      default: w = DIM_W'($urandom_range(12, 3));
    endcase
    // a wider row mid-frame would read line store columns never written
    if (!tracker.at_frame_start() && tracker.width_of(w) > tracker.safe_width()) begin
      w = DIM_W'(tracker.safe_width());
    end
    junk = ($urandom_range(9) == 0) ? CFG_W'({$urandom, $urandom}) : '0;
    queue_write(REG_WIDTH, {junk[CFG_W-1:DIM_W], w});
    case ($urandom_range(9))
      0: h = DIM_W'($urandom_range(2));
      1: h = DIM_W'($urandom_range(8191, 11));
      default: h = DIM_W'($urandom_range(10, 3));
    endcase
    queue_write(REG_HEIGHT, CFG_W'(h));
    if ($urandom_range(4) == 0) begin
      queue_write(CFG_ADDR_W'($urandom_range((1 << CFG_ADDR_W) - 1, REG_HEIGHT + 1)),
                  CFG_W'({$urandom, $urandom}));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: identity kernel over 640-wide rows
    set_idling(IDLE_NONE);
    stream(1300, 1'b0);
    drain();

    // saturation above 255 on a 3x3 frame
    queue_write(REG_WIDTH, CFG_W'(DIM_MIN));
    queue_write(REG_HEIGHT, CFG_W'(DIM_MIN));
    queue_write(REG_COEF_TOP, pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX));
    queue_write(REG_COEF_MIDDLE, pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX));
    queue_write(REG_COEF_BOTTOM, pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX));
    apply_writes();
    push_frame(PIX_MAX, PIX_MAX, 1'b0);
    drain();

    // saturation below zero
    queue_write(REG_COEF_TOP, pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN));
    queue_write(REG_COEF_MIDDLE, pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN));
    queue_write(REG_COEF_BOTTOM, pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN));
    apply_writes();
    push_frame(PIX_MAX, PIX_MAX, 1'b0);
    drain();

    // 1.5 on the center tap: 4.5 truncates to 4
    queue_write(REG_COEF_TOP, '0);
    queue_write(REG_COEF_MIDDLE, pack_coefs('0, COEF_ONE_HALF, '0));
    queue_write(REG_COEF_BOTTOM, '0);
    apply_writes();
    push_frame(PIX_MIN, 8'd3, 1'b1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_setup();
      apply_writes();
      set_idling(idle_mode_e'(ph % 4));
      if (ph == 5) begin
        // sender holds back until the block has delivered everything
        stream(30, 1'b0);
        wait_results();
        stream(30, 1'b0);
      end else begin
        stream($urandom_range(50, 30), 1'b0);
      end
      drain();
    end

    // receiver holds off long enough for the output queue to fill and block input
    queue_write(REG_WIDTH, 48'd5);
    queue_write(REG_HEIGHT, 48'd20);
    apply_writes();
    set_idling(IDLE_NONE);
    rx_hold_request = 300;
    stream(100, 1'b1);
    drain();

    // widest row, saturated from the largest register value
    queue_write(REG_WIDTH, CFG_W'({DIM_W{1'b1}}));
    queue_write(REG_HEIGHT, CFG_W'(DIM_MIN));
    queue_write(REG_COEF_TOP, random_coef_row(0));
    queue_write(REG_COEF_MIDDLE, random_coef_row(0));
    queue_write(REG_COEF_BOTTOM, random_coef_row(0));
    apply_writes();
    set_idling(IDLE_BOTH);
    stream(64, 1'b0);
    drain();

    // tallest frame on the narrowest rows
    queue_write(REG_WIDTH, CFG_W'(DIM_MIN));
    queue_write(REG_HEIGHT, CFG_W'(HEIGHT_CAP));
    apply_writes();
    set_idling(IDLE_NONE);
    stream(60, 1'b0);

    for (int i = 0; i < 20000 && tracker.pending() != 0; i++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    tracker.check_drained();
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> conv3x3_clamped_image_filter.f
+incdir+sv
sv/cv3_pkg.sv
sv/cv3_line_store.sv
sv/cv3_cell.sv
sv/cv3_out_fifo.sv
sv/conv3x3_clamped_image_filter.sv
sv/cv3_checker.sv
tb/testbench.sv
